### src/ssg_pkg.sv
package ssg_pkg;

  // default build parameters
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 8;

  // fixed field widths
  localparam int INC_W      = 32;
  localparam int CNT_W      = 24;
  localparam int AMP_W      = 9;
  localparam int MAG_W      = 17;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // fraction bits of the two scaling paths
  localparam int FRAC_SIN = 24;
  localparam int FRAC_SQR = 8;

  // state store holds a single entry
  localparam int ST_DEPTH = 1;

  // register reset values
  localparam logic [AMP_W-1:0] AMP_RST        = 9'd128;
  localparam logic [INC_W-1:0] START_INC_RST  = 32'd4194304;
  localparam logic [INC_W-1:0] SWEEP_STEP_RST = 32'd419430;
  localparam logic [INC_W-1:0] SWEEP_LOW_RST  = 32'd4194304;
  localparam logic [INC_W-1:0] SWEEP_HIGH_RST = 32'd8388608;
  localparam logic [CNT_W-1:0] SWEEP_INT_RST  = 24'd102400;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WAVE_SELECT     = 3'd0,
    CFG_AMPLITUDE       = 3'd1,
    CFG_START_INCREMENT = 3'd2,
    CFG_SWEEP_STEP      = 3'd3,
    CFG_SWEEP_LOW       = 3'd4,
    CFG_SWEEP_HIGH      = 3'd5,
    CFG_SWEEP_INTERVAL  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL,
    ST_SCL,
    ST_OUT
  } gen_state_t;

  // sine magnitude in q16 for table entry idx of a 2^tbits entry table
  // quarter-wave symmetry over a truncated odd polynomial
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned idx,
                                                input int unsigned tbits);
    longint unsigned q;
    longint unsigned quad;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    q    = longint'(idx) << 2;
    quad = (q >> tbits) & 64'd3;
    x    = (q & ((64'd1 << tbits) - 64'd1)) << (16 - tbits);
    if (quad[0]) begin
      x = 64'd65536 - x;
    end
    x2 = (x * x) >> 16;
    t  = (64'd4640 * x2) >> 16;
    t  = 64'd42047 - t;
    t  = (t * x2) >> 16;
    t  = 64'd102944 - t;
    t  = (t * x) >> 16;
    if (t > 64'd65536) begin
      t = 64'd65536;
    end
    return MAG_W'(t);
  endfunction

endpackage

### src/ssg_ram.sv
module ssg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/swept_sine_square_wave_generator_core.sv
// Swept sine/square DDS core. Each input word is one DAC sample tick and
// yields exactly one output word holding an unsigned SAMPLE_BITS sample and
// a cycle_start flag (carry out of the phase accumulator on that tick). A
// restart bit in the input word clears the phase, reloads the increment from
// start_increment, turns the sweep upward and clears the sweep counter before
// that sample is formed. The generator state (phase, increment, sweep
// direction, sweep counter) lives in a one-entry synchronous RAM; each tick
// reads it, updates it in one pass and writes it back, then the sample is
// scaled through two registered multiplies. The state RAM is read at the
// accepting edge, and the output word then passes these registered steps:
// update and sine table lookup, amplitude multiply, midscale multiply, clamp
// into the output register. The next word is taken once the previous one has
// reached the output register; a stalled output word holds the pipeline at
// its last step. Configuration writes take effect on the next tick, except
// start_increment, which is used only on restart. There is no clearing pass
// after reset: the state entry reads as its reset value until the first tick
// writes it.
module swept_sine_square_wave_generator_core #(
  parameter int TABLE_DEPTH = ssg_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_BITS  = ssg_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = ssg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input stream, one word per sample tick
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [7:0]                              in_tdata,   // [0] restart
  // output stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((SAMPLE_BITS + 8) / 8) * 8-1:0]  out_tdata,  // sample, cycle_start
  // configuration write port
  input  logic                                    cfg_we,
  input  logic [ssg_pkg::CFG_ADDR_W-1:0]          cfg_addr,
  input  logic [ssg_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  import ssg_pkg::*;

  localparam int TB      = $clog2(TABLE_DEPTH);
  localparam int OUT_W   = ((SAMPLE_BITS + 8) / 8) * 8;
  localparam int FULL    = (1 << SAMPLE_BITS) - 1;
  localparam int MID     = FULL / 2;
  localparam int ST_W    = PHASE_BITS + INC_W + 1 + CNT_W;
  localparam int ST_AW   = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
  localparam int P1_W    = MAG_W + AMP_W;
  localparam int P2_W    = P1_W + SAMPLE_BITS - 1;
  localparam int SV_W    = SAMPLE_BITS + 27;
  localparam int SW_W    = SAMPLE_BITS + AMP_W;
  localparam int SQ_W    = SAMPLE_BITS + 11;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic             wave_sel_r;
  logic [AMP_W-1:0] amp_r;
  logic [INC_W-1:0] start_inc_r;
  logic [INC_W-1:0] sweep_step_r;
  logic [INC_W-1:0] sweep_low_r;
  logic [INC_W-1:0] sweep_high_r;
  logic [CNT_W-1:0] sweep_int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_sel_r   <= 1'b0;
      amp_r        <= AMP_RST;
      start_inc_r  <= START_INC_RST;
      sweep_step_r <= SWEEP_STEP_RST;
      sweep_low_r  <= SWEEP_LOW_RST;
      sweep_high_r <= SWEEP_HIGH_RST;
      sweep_int_r  <= SWEEP_INT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_WAVE_SELECT:     wave_sel_r   <= cfg_wdata[0];
        CFG_AMPLITUDE:       amp_r        <= cfg_wdata[AMP_W-1:0];
        CFG_START_INCREMENT: start_inc_r  <= cfg_wdata[INC_W-1:0];
        CFG_SWEEP_STEP:      sweep_step_r <= cfg_wdata[INC_W-1:0];
        CFG_SWEEP_LOW:       sweep_low_r  <= cfg_wdata[INC_W-1:0];
        CFG_SWEEP_HIGH:      sweep_high_r <= cfg_wdata[INC_W-1:0];
        CFG_SWEEP_INTERVAL:  sweep_int_r  <= cfg_wdata[CNT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  gen_state_t state_r, state_nxt;
  logic       out_valid_r;
  logic       out_free;
  logic       accept;
  logic       st_rd_en, st_wr_en, upd_en, mul_en, scl_en, out_load;

  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SCL;
      ST_SCL:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    st_rd_en  = 1'b0;
    st_wr_en  = 1'b0;
    upd_en    = 1'b0;
    mul_en    = 1'b0;
    scl_en    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        st_rd_en  = in_tvalid;
      end
      ST_UPD: begin
        st_wr_en = 1'b1;
        upd_en   = 1'b1;
      end
      ST_MUL:  mul_en = 1'b1;
      ST_SCL:  scl_en = 1'b1;
      ST_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // state RAM: {phase, increment, sweep_down, sweep_count}
  // ---------------------------------------------------------------------------
  logic [ST_W-1:0] st_rd_data;
  logic [ST_W-1:0] st_wr_data;
  logic            st_valid_r;  // entry written since reset
  logic            restart_r;

  ssg_ram #(
    .WIDTH (ST_W),
    .DEPTH (ST_DEPTH)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (ST_AW'(0)),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (ST_AW'(0)),
    .rd_data (st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (st_wr_en) begin
      st_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      restart_r <= in_tdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // update step: phase add, sweep, table lookup
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] sine_rom [TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_mag(k, TB);
  end

  logic [PHASE_BITS-1:0] cur_phase;
  logic [INC_W-1:0]      cur_inc;
  logic                  cur_down;
  logic [CNT_W-1:0]      cur_cnt;
  logic [PHASE_BITS:0]   phase_sum;
  logic [CNT_W:0]        cnt_inc;
  logic [INC_W-1:0]      inc_moved;
  logic [INC_W-1:0]      new_inc;
  logic                  new_down;
  logic [CNT_W-1:0]      new_cnt;

  always_comb begin
    // an unwritten entry reads as its reset value
    if (st_valid_r) begin
      {cur_phase, cur_inc, cur_down, cur_cnt} = st_rd_data;
    end else begin
      cur_phase = '0;
      cur_inc   = START_INC_RST;
      cur_down  = 1'b0;
      cur_cnt   = '0;
    end
    if (restart_r) begin
      cur_phase = '0;
      cur_inc   = start_inc_r;
      cur_down  = 1'b0;
      cur_cnt   = '0;
    end

    phase_sum = {1'b0, cur_phase} + {1'b0, PHASE_BITS'(cur_inc)};

    // triangular sweep, applied after this tick's phase addition
    cnt_inc = {1'b0, cur_cnt} + (CNT_W + 1)'(1);
    if (cur_down) begin
      inc_moved = (cur_inc >= sweep_step_r) ? cur_inc - sweep_step_r : '0;
    end else begin
      inc_moved = (~cur_inc >= sweep_step_r) ? cur_inc + sweep_step_r : '1;
    end
    new_inc  = cur_inc;
    new_down = cur_down;
    new_cnt  = '0;
    if (sweep_int_r != '0) begin
      if (cnt_inc >= {1'b0, sweep_int_r}) begin
        new_inc = inc_moved;
        if (inc_moved >= sweep_high_r) new_down = 1'b1;
        if (inc_moved <= sweep_low_r)  new_down = 1'b0;
      end else begin
        new_cnt = cnt_inc[CNT_W-1:0];
      end
    end

    st_wr_data = {phase_sum[PHASE_BITS-1:0], new_inc, new_down, new_cnt};
  end

  logic [MAG_W-1:0] mag_r;
  logic             ph_msb_r;  // second half of the cycle: negative sine
  logic             carry_r;

  always_ff @(posedge clk) begin
    if (upd_en) begin
      mag_r    <= sine_rom[cur_phase[PHASE_BITS-1 -: TB]];
      ph_msb_r <= cur_phase[PHASE_BITS-1];
      carry_r  <= phase_sum[PHASE_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // scaling: mag*amp, then midscale; square swing alongside
  // ---------------------------------------------------------------------------
  logic [P1_W-1:0] prod1_r;
  logic [P2_W-1:0] prod2_r;
  logic [SW_W-1:0] sq_swing_r;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod1_r    <= P1_W'(mag_r) * P1_W'(amp_r);
      sq_swing_r <= SW_W'(FULL) * SW_W'(amp_r);
    end
    if (scl_en) begin
      prod2_r <= P2_W'(MID) * P2_W'(prod1_r);
    end
  end

  logic [SV_W-1:0]        sin_v;
  logic [SV_W-FRAC_SIN-1:0] sin_int;
  logic [SQ_W-1:0]        sq_v;
  logic [SQ_W-FRAC_SQR-1:0] sq_int;
  logic [SAMPLE_BITS-1:0] sin_smp, sq_smp, smp;

  always_comb begin
    // sine: midscale in q24 plus or minus the scaled swing, two's complement
    if (ph_msb_r) begin
      sin_v = (SV_W'(MID) << FRAC_SIN) - SV_W'(prod2_r);
    end else begin
      sin_v = (SV_W'(MID) << FRAC_SIN) + SV_W'(prod2_r);
    end
    sin_int = sin_v[SV_W-1:FRAC_SIN];
    if (sin_v[SV_W-1]) begin
      sin_smp = '0;
    end else if (sin_int > (SV_W - FRAC_SIN)'(FULL)) begin
      sin_smp = SAMPLE_BITS'(FULL);
    end else begin
      sin_smp = sin_int[SAMPLE_BITS-1:0];
    end

    // square: first half high, second half low, q8
    if (ph_msb_r) begin
      sq_v = (SQ_W'(MID) << FRAC_SQR) - SQ_W'(sq_swing_r);
    end else begin
      sq_v = (SQ_W'(MID) << FRAC_SQR) + SQ_W'(sq_swing_r);
    end
    sq_int = sq_v[SQ_W-1:FRAC_SQR];
    if (sq_v[SQ_W-1]) begin
      sq_smp = '0;
    end else if (sq_int > (SQ_W - FRAC_SQR)'(FULL)) begin
      sq_smp = SAMPLE_BITS'(FULL);
    end else begin
      sq_smp = sq_int[SAMPLE_BITS-1:0];
    end

    smp = wave_sel_r ? sq_smp : sin_smp;
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_W'({carry_r, smp});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // an accepted word always goes straight to the update step
  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_UPD))
    else $error("accepted word did not enter update step");

  // once written, the state entry stays valid until reset
  a_state_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid_r |=> st_valid_r)
    else $error("state entry lost its valid mark");

  // the last step always lands a word in the output register
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUT) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result word not loaded at end of tick");

  // no state write without a preceding read of the entry
  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr_en |-> $past(st_rd_en))
    else $error("state write without read");
`endif

endmodule

### sim/testbench.sv
module testbench;

  import ssg_pkg::*;

  // wave select codes
  localparam logic WAVE_SINE   = 1'b0;
  localparam logic WAVE_SQUARE = 1'b1;

  // output word layout, sample in the low byte
  localparam int OUT_W = ((SAMPLE_BITS_DEF + 8) / 8) * 8;

  // dac level constants
  localparam longint LVL_MID  = 127;
  localparam longint LVL_FULL = 255;

  // drain wait after the last predicted word has come out
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] sample;
    logic       wrap;
  } dac_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'd0;   // [0] restart
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // [7:0] sample, [8] cycle_start
  logic             cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  swept_sine_square_wave_generator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic        reg_wave;
  logic [8:0]  reg_amp;
  logic [31:0] reg_start;
  logic [31:0] reg_step;
  logic [31:0] reg_low;
  logic [31:0] reg_high;
  logic [23:0] reg_interval;

  // generator state mirror
  logic [31:0] acc_phase;
  logic [31:0] acc_inc;
  logic        sweeping_down;
  logic [23:0] tick_count;

  // samples predicted but not yet seen on the output
  dac_word_t   pending_samples[$];
  int unsigned bad_words = 0;

  // traffic shaping knobs
  bit          gaps_on = 1'b1;
  bit          rx_steady = 1'b0;
  int unsigned burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_phase = 0;

  // q16 sine magnitude of rom entry idx, quarter-wave folded polynomial
  function automatic longint unsigned sine_q16(input logic [7:0] idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x = 64'(idx[5:0]) << 10;
    // odd quadrants run the quarter wave backwards
    if (idx[6]) begin
      x = 64'd65536 - x;
    end
    x2 = (x * x) >> 16;
    t  = (64'd4640 * x2) >> 16;
    t  = (64'd42047 - t) * x2 >> 16;
    t  = ((64'd102944 - t) * x) >> 16;
    return (t > 64'd65536) ? 64'd65536 : t;
  endfunction

  // floor to integer level, clamp to 0..255
  function automatic logic [7:0] clip_level(input longint v, input int frac);
    longint r;
    if (v < 0) begin
      return 8'd0;
    end
    r = v >>> frac;
    return (r > LVL_FULL) ? 8'hFF : r[7:0];
  endfunction

  // dac level for the current phase and settings
  function automatic logic [7:0] wave_level(input logic [31:0] ph);
    longint amp;
    longint mag;
    amp = longint'(reg_amp);
    if (reg_wave == WAVE_SQUARE) begin
      // high in the first half cycle, low in the second
      return clip_level(ph[31] ? (LVL_MID * 256) - LVL_FULL * amp
                               : (LVL_MID * 256) + LVL_FULL * amp, FRAC_SQR);
    end
    mag = longint'(sine_q16(ph[31:24]));
    // second half of the table is the negative lobe
    return clip_level(ph[31] ? (LVL_MID <<< 24) - LVL_MID * mag * amp
                             : (LVL_MID <<< 24) + LVL_MID * mag * amp, FRAC_SIN);
  endfunction

  function automatic void reset_generator();
    reg_wave      = WAVE_SINE;
    reg_amp       = AMP_RST;
    reg_start     = START_INC_RST;
    reg_step      = SWEEP_STEP_RST;
    reg_low       = SWEEP_LOW_RST;
    reg_high      = SWEEP_HIGH_RST;
    reg_interval  = SWEEP_INT_RST;
    acc_phase     = '0;
    acc_inc       = START_INC_RST;
    sweeping_down = 1'b0;
    tick_count    = '0;
  endfunction

  // one sample tick: form sample, advance phase, then run the sweep
  function automatic void predict_sample(input logic restart);
    dac_word_t   w;
    logic [32:0] sum;
    if (restart) begin
      acc_phase     = '0;
      acc_inc       = reg_start;
      sweeping_down = 1'b0;
      tick_count    = '0;
    end
    w.sample  = wave_level(acc_phase);
    sum       = {1'b0, acc_phase} + {1'b0, acc_inc};
    w.wrap    = sum[32];
    acc_phase = sum[31:0];
    if (reg_interval == '0) begin
      // sweeping disabled, counter parked
      tick_count = '0;
    end else if ({1'b0, tick_count} + 25'd1 >= {1'b0, reg_interval}) begin
      tick_count = '0;
      if (sweeping_down) begin
        acc_inc = (acc_inc >= reg_step) ? acc_inc - reg_step : 32'd0;
      end else begin
        acc_inc = (~acc_inc >= reg_step) ? acc_inc + reg_step : 32'hFFFF_FFFF;
      end
      // low bound checked last so it wins when both hold
      if (acc_inc >= reg_high) begin
        sweeping_down = 1'b1;
      end
      if (acc_inc <= reg_low) begin
        sweeping_down = 1'b0;
      end
    end else begin
      tick_count = tick_count + 24'd1;
    end
    pending_samples.push_back(w);
  endfunction

  // compare one output word with the oldest prediction
  task automatic check_word(input logic [OUT_W-1:0] data);
    dac_word_t want;
    if (pending_samples.size() == 0) begin
      bad_words++;
      if (bad_words <= 10) begin
        $display("unexpected word: sample %0d cycle_start %0b", data[7:0], data[8]);
      end
    end else begin
      want = pending_samples.pop_front();
      if (data[7:0] !== want.sample || data[8] !== want.wrap) begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("word mismatch: sample exp %0d got %0d, cycle_start exp %0b got %0b",
                   want.sample, data[7:0], want.wrap, data[8]);
        end
      end
    end
  endtask

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_word(out_tdata);
    end
  end

  // receiver backpressure: steady, coin flip or a 3-of-7 stall pattern
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode  = $urandom_range(0, 2);
      rx_hold  = $urandom_range(20, 200);
      rx_phase = 0;
    end
    rx_hold--;
    rx_phase++;
    if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ((rx_phase % 7) < 4);
      endcase
    end
  end

  // drive one sample tick word, bursts with random gaps between them
  task automatic send_word(input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(restart);
    burst_left--;
    @(negedge clk);
  endtask

  // stop the input and let every predicted word come out
  task automatic wait_all_samples();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_WAVE_SELECT:     reg_wave     = val[0];
      CFG_AMPLITUDE:       reg_amp      = val[8:0];
      CFG_START_INCREMENT: reg_start    = val;
      CFG_SWEEP_STEP:      reg_step     = val;
      CFG_SWEEP_LOW:       reg_low      = val;
      CFG_SWEEP_HIGH:      reg_high     = val;
      CFG_SWEEP_INTERVAL:  reg_interval = val[23:0];
      default: ;
    endcase
  endtask

  // full register set, only called with the block idle
  task automatic load_settings(input logic wave, input logic [8:0] amp,
                               input logic [31:0] start, input logic [31:0] step,
                               input logic [31:0] low, input logic [31:0] high,
                               input logic [23:0] interval);
    write_reg(CFG_WAVE_SELECT, {31'd0, wave});
    write_reg(CFG_AMPLITUDE, {23'd0, amp});
    write_reg(CFG_START_INCREMENT, start);
    write_reg(CFG_SWEEP_STEP, step);
    write_reg(CFG_SWEEP_LOW, low);
    write_reg(CFG_SWEEP_HIGH, high);
    write_reg(CFG_SWEEP_INTERVAL, {8'd0, interval});
  endtask

  // increments and bounds with a bias toward the edges
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return $urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_interval();
    case ($urandom_range(0, 5))
      0:       return 24'd0;
      1:       return 24'hFF_FFFF;
      2, 3:    return 24'($urandom_range(1, 4));
      default: return 24'($urandom_range(5, 40));
    endcase
  endfunction

  function automatic logic [8:0] pick_amp();
    case ($urandom_range(0, 4))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'd511;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // reset values, restart in the middle of a run
  task automatic test_reset_defaults();
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    wait_all_samples();
  endtask

  // quarter-cycle steps land on the peaks and zero crossings
  task automatic test_sine_extremes();
    load_settings(WAVE_SINE, 9'd256, 32'h4000_0000, 32'd0, 32'd0, 32'hFFFF_FFFF, 24'd0);
    send_word(1'b1);
    repeat (4) send_word(1'b0);
    wait_all_samples();
    // amplitude above full scale hits both rails
    write_reg(CFG_AMPLITUDE, 32'd511);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    wait_all_samples();
  endtask

  // square at zero, full, overdriven amp; carry every other tick at first
  task automatic test_square_extremes();
    load_settings(WAVE_SQUARE, 9'd0, 32'h8000_0000, 32'd0, 32'd0, 32'hFFFF_FFFF, 24'd0);
    send_word(1'b1);
    send_word(1'b0);
    wait_all_samples();
    write_reg(CFG_AMPLITUDE, 32'd256);
    send_word(1'b0);
    send_word(1'b0);
    wait_all_samples();
    write_reg(CFG_AMPLITUDE, 32'd511);
    write_reg(CFG_START_INCREMENT, 32'hFFFF_FFFF);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    wait_all_samples();
  endtask

  // sweep every tick with huge steps, saturating at both ends
  task automatic test_sweep_saturation();
    load_settings(WAVE_SQUARE, 9'd200, 32'hFFFF_FFF0, 32'h8000_0000, 32'd0,
                  32'hFFFF_FFFF, 24'd1);
    send_word(1'b1);
    repeat (50) send_word($urandom_range(0, 15) == 0);
    wait_all_samples();
    // crossed bounds, low must win
    load_settings(WAVE_SINE, 9'd256, 32'h0800_0000, 32'h0300_0000, 32'hF000_0000,
                  32'h1000_0000, 24'd2);
    send_word(1'b1);
    repeat (50) send_word($urandom_range(0, 15) == 0);
    wait_all_samples();
  endtask

  // random settings per round, random restarts inside
  task automatic test_random_rounds();
    int unsigned n;
    for (int round = 0; round < 10; round++) begin
      gaps_on   = (round != 0);
      rx_steady = (round == 0 || round == 3);
      load_settings(1'($urandom_range(0, 1)), pick_amp(), pick_word(), pick_word(),
                    pick_word(), pick_word(), pick_interval());
      n = $urandom_range(100, 140);
      send_word($urandom_range(0, 3) != 0);
      for (int i = 1; i < n; i++) begin
        // hold off once mid-round until the output side is empty
        if (round == 4 && i == 60) begin
          wait_all_samples();
        end
        send_word($urandom_range(0, 31) == 0);
      end
      wait_all_samples();
    end
    gaps_on   = 1'b1;
    rx_steady = 1'b0;
  endtask

  initial begin
    reset_generator();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_sine_extremes();
    test_square_extremes();
    test_sweep_saturation();
    test_random_rounds();
    wait_all_samples();
    repeat (10) @(negedge clk);
    if (bad_words == 0 && pending_samples.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
